FILE: rtl/tmc_pkg.sv
// Shared constants, codes and types for the tile map collision engine.
package tmc_pkg;

   localparam int GRID_W_DEF  = 32;
   localparam int GRID_H_DEF  = 32;
   localparam int TILE_PX_DEF = 32;
   localparam int KIND_COUNT  = 4;

   localparam int KIND_W  = 2;
   localparam int FUNC_W  = 2;
   localparam int XY_W    = 16;
   localparam int EXT_W   = 12;
   localparam int MASK_W  = 4;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 16;
   // signed pixel math: offset and extent sums, grid span up to 256*256
   localparam int COORD_W = 20;

   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BOX    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [CSR_A_W-1:0] CSR_SOLID_MASK = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_OFFSET_X   = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_OFFSET_Y   = 2'd2;

   localparam logic [MASK_W-1:0] SOLID_MASK_RST = 4'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COLS,
      ST_ROWS,
      ST_DRAIN,
      ST_WR_RD,
      ST_WR_WR,
      ST_FINISH
   } state_type;

endpackage

FILE: rtl/tmc_span_unit.sv
// Shared span compare: does the tile starting at pos overlap the open interval (lo, hi).
module tmc_span_unit #(
   parameter int TILE_PX = tmc_pkg::TILE_PX_DEF
) (
   input  logic signed [tmc_pkg::COORD_W-1:0] pos,
   input  logic signed [tmc_pkg::COORD_W-1:0] hi,
   input  logic signed [tmc_pkg::COORD_W-1:0] lo,
   output logic                               hit
);
   import tmc_pkg::*;

   localparam logic signed [COORD_W-1:0] TILE_LAST = COORD_W'(TILE_PX - 1);

   logic signed [COORD_W-1:0] far_edge;

   assign far_edge = pos + TILE_LAST;
   assign hit      = (pos < hi) && (far_edge > lo);

endmodule

FILE: rtl/tmc_row_mem.sv
// Row-organized tile grid memory with per-row valid bits; unwritten rows read as zero.
module tmc_row_mem #(
   parameter int ROWS     = 32,
   parameter int ROW_BITS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rd_en,
   input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] rd_addr,
   input  logic                                   wr_en,
   input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] wr_addr,
   input  logic [ROW_BITS-1:0]                    wr_data,
   output logic [ROW_BITS-1:0]                    rd_data
);
   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROWS-1:0]     row_valid_ff;
   logic [ROW_BITS-1:0] rd_data_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/tmc_row_eval.sv
// Reduces one grid row against the column mask: solid overlap and selected kind.
module tmc_row_eval #(
   parameter int GRID_W = tmc_pkg::GRID_W_DEF
) (
   input  logic [GRID_W*tmc_pkg::KIND_W-1:0] row_data,
   input  logic [GRID_W-1:0]                 col_mask,
   input  logic [tmc_pkg::MASK_W-1:0]        solid_mask,
   output logic                              solid_hit,
   output logic [tmc_pkg::KIND_W-1:0]        sel_kind
);
   import tmc_pkg::*;

   always_comb begin
      logic [KIND_W-1:0] k;
      solid_hit = 1'b0;
      sel_kind  = '0;
      for (int c = 0; c < GRID_W; c++) begin
         k = row_data[c*KIND_W +: KIND_W];
         solid_hit = solid_hit | (col_mask[c] & solid_mask[k]);
         sel_kind  = sel_kind | (col_mask[c] ? k : '0);
      end
   end

endmodule

FILE: rtl/tile_map_collision_engine_core.sv
// Tile map collision engine: grid store, point lookup and box overlap query.
//
// Usage: one item enters on the req_ channel (valid/ready) and yields exactly one
// result on the rsp_ channel. func selects write tile, box query or point lookup.
// Configuration (solid mask, map offsets) is written through csr_we/csr_index/
// csr_wdata while the block is idle; no wait, no read-back.
// Steps from transfer on req_ to rsp_valid:
//   accepted write: row read, row write back, result load
//   rejected write or unused code: result load only
//   box query or lookup: column sweep, row sweep, drain, result load
// The block passes through idle after each item and takes the next item there.
// One span comparator is reused: it sweeps the columns once, one per cycle, to
// build a column mask, then sweeps the rows, one per cycle, while each row word is
// read from the grid memory and reduced against that mask.
// One item is in flight at a time; req_ready is high only when idle. The result
// sits in an output register, so a new item may be taken while rsp_ready is low;
// the block then holds its finished result until the register frees up.
// Reset: grid reads as all kind 0 (per-row valid bits, cleared at once), solid
// mask 5, offsets 0, no result pending. No clearing pass is needed.
module tile_map_collision_engine_core #(
   parameter int GRID_W  = tmc_pkg::GRID_W_DEF,
   parameter int GRID_H  = tmc_pkg::GRID_H_DEF,
   parameter int TILE_PX = tmc_pkg::TILE_PX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tmc_pkg::FUNC_W-1:0]         req_func,
   input  logic [tmc_pkg::KIND_W-1:0]         req_tile_kind,
   input  logic signed [tmc_pkg::XY_W-1:0]    req_at_x,
   input  logic signed [tmc_pkg::XY_W-1:0]    req_at_y,
   input  logic [tmc_pkg::EXT_W-1:0]          req_extent_x,
   input  logic [tmc_pkg::EXT_W-1:0]          req_extent_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_collides,
   output logic [tmc_pkg::KIND_W-1:0]         rsp_found_kind,
   output logic                               rsp_found_solid,
   output logic                               rsp_write_done,
   input  logic                               csr_we,
   input  logic [tmc_pkg::CSR_A_W-1:0]        csr_index,
   input  logic [tmc_pkg::CSR_D_W-1:0]        csr_wdata
);
   import tmc_pkg::*;

   localparam int COL_W    = (GRID_W > 1) ? $clog2(GRID_W) : 1;
   localparam int ROW_W    = (GRID_H > 1) ? $clog2(GRID_H) : 1;
   localparam int IDX_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int ROW_BITS = GRID_W * KIND_W;
   localparam logic [IDX_W-1:0] COL_LAST = IDX_W'(GRID_W - 1);
   localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(GRID_H - 1);
   localparam logic signed [COORD_W-1:0] TILE_STEP = COORD_W'(TILE_PX);
   localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1);

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]         func_ff, func_in;
   logic [KIND_W-1:0]         kind_ff, kind_in;
   logic [XY_W-1:0]           at_x_ff, at_x_in;
   logic [XY_W-1:0]           at_y_ff, at_y_in;
   logic                      wr_ok_ff, wr_ok_in;
   logic signed [COORD_W-1:0] xa_ff, xa_in, xb_ff, xb_in;
   logic signed [COORD_W-1:0] ya_ff, ya_in, yb_ff, yb_in;
   logic [IDX_W-1:0]          cnt_ff, cnt_in;
   logic signed [COORD_W-1:0] pos_ff, pos_in;
   logic [GRID_W-1:0]         col_mask_ff, col_mask_in;
   logic                      evl_vld_ff, evl_vld_in;
   logic                      yhit_ff, yhit_in;
   logic                      hit_ff, hit_in;
   logic [KIND_W-1:0]         fkind_ff, fkind_in;
   logic [MASK_W-1:0]         solid_mask_ff, solid_mask_in;
   logic [XY_W-1:0]           offset_x_ff, offset_x_in;
   logic [XY_W-1:0]           offset_y_ff, offset_y_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_collides_ff, rsp_collides_in;
   logic [KIND_W-1:0]         rsp_found_kind_ff, rsp_found_kind_in;
   logic                      rsp_found_solid_ff, rsp_found_solid_in;
   logic                      rsp_write_done_ff, rsp_write_done_in;

   logic                      req_xfer;
   logic                      rsp_load;
   logic                      req_wr_ok;
   logic signed [COORD_W-1:0] sx, sy, ex, ey, ox, oy;
   logic signed [COORD_W-1:0] span_hi, span_lo;
   logic                      span_hit;
   logic                      mem_rd_en, mem_wr_en;
   logic [ROW_W-1:0]          mem_rd_addr;
   logic [ROW_BITS-1:0]       mem_rd_data, row_mod;
   logic                      row_hit;
   logic [KIND_W-1:0]         row_kind;

   // ---------------- shared units ----------------
   tmc_span_unit #(
      .TILE_PX (TILE_PX)
   ) u_span (
      .pos (pos_ff),
      .hi  (span_hi),
      .lo  (span_lo),
      .hit (span_hit)
   );

   tmc_row_mem #(
      .ROWS     (GRID_H),
      .ROW_BITS (ROW_BITS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .wr_en   (mem_wr_en),
      .wr_addr (at_y_ff[ROW_W-1:0]),
      .wr_data (row_mod),
      .rd_data (mem_rd_data)
   );

   tmc_row_eval #(
      .GRID_W (GRID_W)
   ) u_eval (
      .row_data   (mem_rd_data),
      .col_mask   (col_mask_ff),
      .solid_mask (solid_mask_ff),
      .solid_hit  (row_hit),
      .sel_kind   (row_kind)
   );

   // ---------------- input decode ----------------
   assign req_xfer = req_valid & req_ready;

   assign sx = COORD_W'(req_at_x);
   assign sy = COORD_W'(req_at_y);
   assign ex = $signed({{(COORD_W - EXT_W){1'b0}}, req_extent_x});
   assign ey = $signed({{(COORD_W - EXT_W){1'b0}}, req_extent_y});
   assign ox = COORD_W'($signed(offset_x_ff));
   assign oy = COORD_W'($signed(offset_y_ff));

   assign req_wr_ok = (req_at_x >= 0) && (req_at_x < XY_W'(GRID_W)) &&
                      (req_at_y >= 0) && (req_at_y < XY_W'(GRID_H)) &&
                      ({3'b000, req_tile_kind} < 5'(KIND_COUNT));

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if ((req_func == FUNC_WRITE) && req_wr_ok) begin
                  state_in = ST_WR_RD;
               end else if ((req_func == FUNC_BOX) || (req_func == FUNC_LOOKUP)) begin
                  state_in = ST_COLS;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_COLS: begin
            if (cnt_ff == COL_LAST) begin
               state_in = ST_ROWS;
            end
         end
         ST_ROWS: begin
            if (cnt_ff == ROW_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_WR_RD:  state_in = ST_WR_WR;
         ST_WR_WR:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      req_ready   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_rd_addr = cnt_ff[ROW_W-1:0];
      span_hi     = xa_ff;
      span_lo     = xb_ff;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_COLS:  ;
         ST_ROWS: begin
            mem_rd_en = 1'b1;
            span_hi   = ya_ff;
            span_lo   = yb_ff;
         end
         ST_DRAIN: ;
         ST_WR_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = at_y_ff[ROW_W-1:0];
         end
         ST_WR_WR:  mem_wr_en = 1'b1;
         ST_FINISH: rsp_load  = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      row_mod = mem_rd_data;
      for (int c = 0; c < GRID_W; c++) begin
         if (COL_W'(c) == at_x_ff[COL_W-1:0]) begin
            row_mod[c*KIND_W +: KIND_W] = kind_ff;
         end
      end
   end

   always_comb begin
      func_in     = func_ff;
      kind_in     = kind_ff;
      at_x_in     = at_x_ff;
      at_y_in     = at_y_ff;
      wr_ok_in    = wr_ok_ff;
      xa_in       = xa_ff;
      xb_in       = xb_ff;
      ya_in       = ya_ff;
      yb_in       = yb_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      col_mask_in = col_mask_ff;
      hit_in      = hit_ff;
      fkind_in    = fkind_ff;
      evl_vld_in  = (state_ff == ST_ROWS);
      yhit_in     = span_hit;

      if (req_xfer) begin
         func_in  = req_func;
         kind_in  = req_tile_kind;
         at_x_in  = req_at_x;
         at_y_in  = req_at_y;
         wr_ok_in = req_wr_ok;
         cnt_in   = '0;
         pos_in   = '0;
         hit_in   = 1'b0;
         fkind_in = '0;
         if (req_func == FUNC_BOX) begin
            xa_in = sx + ex - ox;
            xb_in = sx - ox;
            ya_in = sy + ey - oy;
            yb_in = sy - oy;
         end else begin
            // lookup: the one tile with pos <= at < pos + TILE_PX
            xa_in = sx + ONE;
            xb_in = sx - ONE;
            ya_in = sy + ONE;
            yb_in = sy - ONE;
         end
      end

      if (state_ff == ST_COLS) begin
         col_mask_in[cnt_ff[COL_W-1:0]] = span_hit;
         if (cnt_ff == COL_LAST) begin
            cnt_in = '0;
            pos_in = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            pos_in = pos_ff + TILE_STEP;
         end
      end else if (state_ff == ST_ROWS) begin
         cnt_in = cnt_ff + 1'b1;
         pos_in = pos_ff + TILE_STEP;
      end

      if (evl_vld_ff) begin
         hit_in   = hit_ff | (yhit_ff & row_hit);
         fkind_in = fkind_ff | (yhit_ff ? row_kind : '0);
      end
   end

   // ---------------- configuration ----------------
   always_comb begin
      solid_mask_in = solid_mask_ff;
      offset_x_in   = offset_x_ff;
      offset_y_in   = offset_y_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SOLID_MASK: solid_mask_in = csr_wdata[MASK_W-1:0];
            CSR_OFFSET_X:   offset_x_in   = csr_wdata;
            CSR_OFFSET_Y:   offset_y_in   = csr_wdata;
            default:        ;
         endcase
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in       = rsp_valid_ff & ~rsp_ready;
      rsp_collides_in    = rsp_collides_ff;
      rsp_found_kind_in  = rsp_found_kind_ff;
      rsp_found_solid_in = rsp_found_solid_ff;
      rsp_write_done_in  = rsp_write_done_ff;
      if (rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_collides_in    = (func_ff == FUNC_BOX) & hit_ff;
         rsp_found_kind_in  = (func_ff == FUNC_LOOKUP) ? fkind_ff : '0;
         rsp_found_solid_in = (func_ff == FUNC_LOOKUP) & solid_mask_ff[fkind_ff];
         rsp_write_done_in  = (func_ff == FUNC_WRITE) & wr_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         evl_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         solid_mask_ff <= SOLID_MASK_RST;
         offset_x_ff   <= '0;
         offset_y_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         evl_vld_ff    <= evl_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         solid_mask_ff <= solid_mask_in;
         offset_x_ff   <= offset_x_in;
         offset_y_ff   <= offset_y_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff            <= func_in;
      kind_ff            <= kind_in;
      at_x_ff            <= at_x_in;
      at_y_ff            <= at_y_in;
      wr_ok_ff           <= wr_ok_in;
      xa_ff              <= xa_in;
      xb_ff              <= xb_in;
      ya_ff              <= ya_in;
      yb_ff              <= yb_in;
      cnt_ff             <= cnt_in;
      pos_ff             <= pos_in;
      col_mask_ff        <= col_mask_in;
      yhit_ff            <= yhit_in;
      hit_ff             <= hit_in;
      fkind_ff           <= fkind_in;
      rsp_collides_ff    <= rsp_collides_in;
      rsp_found_kind_ff  <= rsp_found_kind_in;
      rsp_found_solid_ff <= rsp_found_solid_in;
      rsp_write_done_ff  <= rsp_write_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_collides    = rsp_collides_ff;
   assign rsp_found_kind  = rsp_found_kind_ff;
   assign rsp_found_solid = rsp_found_solid_ff;
   assign rsp_write_done  = rsp_write_done_ff;

endmodule
